@@ rtl/bcpa_pkg.sv @@
// Shared constants, codes and types of the bitmap page allocator.
package bcpa_pkg;

  // Page range and derived widths
  localparam int unsigned NUM_PAGES = 4096;
  localparam int unsigned PAGE_W    = $clog2(NUM_PAGES);
  localparam int unsigned CNT_W     = PAGE_W + 1;
  localparam int unsigned SUM_W     = CNT_W + 1;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned LANE_W    = $clog2(BYTE_BITS);
  localparam int unsigned MAP_BYTES = NUM_PAGES / BYTE_BITS;
  localparam int unsigned BYTE_W    = PAGE_W - LANE_W;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    op_e                opcode;
    logic [PAGE_W-1:0]  start_page;
    logic [CNT_W-1:0]   page_count;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [PAGE_W-1:0]  granted_page;
    logic               needs_zeroing;
  } res_t;

  // High-water raise requested by the engine
  typedef struct packed {
    logic               en;
    logic [CNT_W-1:0]   page;
  } hwm_upd_t;

endpackage

@@ rtl/bcpa_intf.sv @@
// Valid/ready channel interfaces of the bitmap page allocator.

// Request channel
interface bcpa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [bcpa_pkg::PAGE_W-1:0]  start_page;
  logic [bcpa_pkg::CNT_W-1:0]   page_count;

  modport source (output valid, opcode, start_page, page_count, input ready);
  modport sink   (input valid, opcode, start_page, page_count, output ready);
endinterface

// Response channel
interface bcpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [bcpa_pkg::PAGE_W-1:0]  granted_page;
  logic                         needs_zeroing;

  modport source (output valid, status, granted_page, needs_zeroing, input ready);
  modport sink   (input valid, status, granted_page, needs_zeroing, output ready);
endinterface

// Configuration write channel
interface bcpa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bcpa_pkg::CNT_W-1:0]   reserved_pages;

  modport source (output valid, reserved_pages, input ready);
  modport sink   (input valid, reserved_pages, output ready);
endinterface

@@ rtl/bitmap_contiguous_page_allocator.sv @@
// Steps: allocate scans map bytes for a free run, then marks the run's bytes; free clears
// the run's bytes; a zero count or bad free range is answered without touching the map.
// One item at a time; throughput is set by the 512 x 8 used-map memory, one byte a cycle.
// The response register lets the next request enter while a result waits.
// Reset: async active low; a clearing pass zeroes every map byte before the first
// request is taken (configuration writes are taken throughout).
module bitmap_contiguous_page_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcpa_req_if.sink    req_i,
  bcpa_rsp_if.source  rsp_o,
  bcpa_cfg_if.sink    cfg_i
);
  import bcpa_pkg::*;

  logic [CNT_W-1:0] reserved_q, reserved_d;
  logic [CNT_W-1:0] hwm_q, hwm_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q;

  req_t             eng_req;
  res_t             eng_res;
  hwm_upd_t         hwm_upd;
  logic             eng_done;
  logic             take;
  logic             cfg_acc;
  logic [CNT_W-1:0] cfg_lim;

  assign eng_req.opcode     = op_e'(req_i.opcode);
  assign eng_req.start_page = req_i.start_page;
  assign eng_req.page_count = req_i.page_count;

  bcpa_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (eng_req),
    .reserved_i  (reserved_q),
    .hwm_i       (hwm_q),
    .done_o      (eng_done),
    .take_i      (take),
    .res_o       (eng_res),
    .hwm_upd_o   (hwm_upd)
  );

  // Configuration: reserved count, raises the high-water mark
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;
  assign cfg_lim     = (cfg_i.reserved_pages > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                                 : cfg_i.reserved_pages;

  always_comb begin
    reserved_d = reserved_q;
    hwm_d      = hwm_q;
    if (cfg_acc) begin
      reserved_d = cfg_i.reserved_pages;
      if (cfg_lim > hwm_q) begin
        hwm_d = cfg_lim;
      end
    end else if (hwm_upd.en) begin
      hwm_d = hwm_upd.page;
    end
  end

  // Response register
  assign take = eng_done & (~out_valid_q | rsp_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q  <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      reserved_q  <= reserved_d;
      hwm_q       <= hwm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_res_q <= eng_res;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_res_q.status;
  assign rsp_o.granted_page  = out_res_q.granted_page;
  assign rsp_o.needs_zeroing = out_res_q.needs_zeroing;

`ifndef ASSERT_OFF
  // A request transfer keeps the engine busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while previous one in progress");

  // Failed requests never grant pages or ask for zeroing
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_DONE)) |->
      ((rsp_o.granted_page == '0) && !rsp_o.needs_zeroing))
    else $error("failed response carries a grant");

  // The high-water mark only grows
  a_hwm_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q >= $past(hwm_q))
    else $error("high-water mark decreased");
`endif

endmodule

@@ rtl/bcpa_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module bcpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bcpa_byte_scan.sv @@
// First-fit run tracking over the eight pages of one map byte.
module bcpa_byte_scan (
  input  logic [bcpa_pkg::BYTE_W-1:0]    base_i,
  input  logic [bcpa_pkg::BYTE_BITS-1:0] busy_i,
  input  logic [bcpa_pkg::CNT_W-1:0]     run_i,
  input  logic [bcpa_pkg::PAGE_W-1:0]    first_i,
  input  logic [bcpa_pkg::CNT_W-1:0]     count_i,
  output logic [bcpa_pkg::CNT_W-1:0]     run_o,
  output logic [bcpa_pkg::PAGE_W-1:0]    first_o,
  output logic                           found_o,
  output logic [bcpa_pkg::PAGE_W-1:0]    last_o
);
  import bcpa_pkg::*;

  // Walk the byte low page first; stop once the run is long enough
  always_comb begin
    logic [CNT_W-1:0]  run;
    logic [PAGE_W-1:0] first;
    logic              found;
    logic [PAGE_W-1:0] last;
    logic [PAGE_W-1:0] pg;
    run   = run_i;
    first = first_i;
    found = 1'b0;
    last  = '0;
    for (int i = 0; i < BYTE_BITS; i++) begin
      pg = {base_i, LANE_W'(i)};
      if (!found) begin
        if (busy_i[i]) begin
          run = '0;
        end else begin
          if (run == '0) begin
            first = pg;
          end
          run = run + CNT_W'(1);
          if (run >= count_i) begin
            found = 1'b1;
            last  = pg;
          end
        end
      end
    end
    run_o   = run;
    first_o = first;
    found_o = found;
    last_o  = last;
  end

endmodule

@@ rtl/bcpa_engine.sv @@
// Allocation engine: map clearing, byte-wise first-fit scan, run mark/clear.
module bcpa_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  bcpa_pkg::req_t            req_i,
  input  logic [bcpa_pkg::CNT_W-1:0] reserved_i,
  input  logic [bcpa_pkg::CNT_W-1:0] hwm_i,
  output logic                      done_o,
  input  logic                      take_i,
  output bcpa_pkg::res_t            res_o,
  output bcpa_pkg::hwm_upd_t        hwm_upd_o
);
  import bcpa_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_MREAD = 6'b001000,
    S_MARK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [BYTE_W-1:0]    cur_q, cur_d;
  logic [CNT_W-1:0]     run_q, run_d;
  logic [PAGE_W-1:0]    first_q, first_d;
  logic [PAGE_W-1:0]    lo_q, lo_d;
  logic [PAGE_W-1:0]    hi_q, hi_d;
  logic                 set_q, set_d;
  logic [CNT_W-1:0]     count_q, count_d;
  res_t                 res_q, res_d;

  logic                 ram_we;
  logic [BYTE_W-1:0]    ram_waddr;
  logic [BYTE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [BYTE_W-1:0]    ram_raddr;
  logic [BYTE_BITS-1:0] ram_rdata;

  logic [BYTE_BITS-1:0] busy;
  logic [BYTE_BITS-1:0] mark_mask;
  logic [BYTE_BITS-1:0] mark_data;
  logic [CNT_W-1:0]     run_n;
  logic [PAGE_W-1:0]    first_n;
  logic                 found_n;
  logic [PAGE_W-1:0]    last_n;
  logic [CNT_W-1:0]     end_page;
  logic [SUM_W-1:0]     free_sum;
  logic                 free_bad;
  logic [PAGE_W-1:0]    free_hi;
  logic                 req_acc;
  logic [BYTE_W-1:0]    cur_inc;

  bcpa_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bcpa_byte_scan u_scan (
    .base_i  (cur_q),
    .busy_i  (busy),
    .run_i   (run_q),
    .first_i (first_q),
    .count_i (count_q),
    .run_o   (run_n),
    .first_o (first_n),
    .found_o (found_n),
    .last_o  (last_n)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign req_acc     = req_valid_i & req_ready_o;
  assign done_o      = (state_q == S_DONE);
  assign res_o       = res_q;
  assign cur_inc     = cur_q + BYTE_W'(1);
  assign end_page    = CNT_W'(last_n) + CNT_W'(1);

  // Free range check and last page of the run
  assign free_sum = SUM_W'(req_i.start_page) + SUM_W'(req_i.page_count);
  assign free_bad = free_sum > SUM_W'(NUM_PAGES);
  assign free_hi  = free_sum[PAGE_W-1:0] - PAGE_W'(1);

  // Busy pages of the byte just read: map bit, reserved range, page zero
  always_comb begin
    logic [PAGE_W-1:0] pg;
    for (int i = 0; i < BYTE_BITS; i++) begin
      pg      = {cur_q, LANE_W'(i)};
      busy[i] = ram_rdata[i] | (CNT_W'(pg) < reserved_i) | (pg == '0);
    end
  end

  // Pages of the current byte inside the run being marked or cleared
  always_comb begin
    logic [PAGE_W-1:0] pg;
    for (int i = 0; i < BYTE_BITS; i++) begin
      pg           = {cur_q, LANE_W'(i)};
      mark_mask[i] = (pg >= lo_q) && (pg <= hi_q);
    end
  end

  assign mark_data = set_q ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    run_d     = run_q;
    first_d   = first_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    set_d     = set_q;
    count_d   = count_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cur_inc;
    hwm_upd_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (cur_q == BYTE_W'(MAP_BYTES - 1)) begin
          cur_d   = '0;
          state_d = S_IDLE;
        end else begin
          cur_d = cur_inc;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          count_d             = req_i.page_count;
          run_d               = '0;
          first_d             = '0;
          set_d               = (req_i.opcode == OP_ALLOC);
          res_d.status        = ST_DONE;
          res_d.granted_page  = '0;
          res_d.needs_zeroing = 1'b0;
          if (req_i.page_count == '0) begin
            res_d.status = ST_RANGE;
            state_d      = S_DONE;
          end else if (req_i.opcode == OP_FREE) begin
            if (free_bad) begin
              res_d.status = ST_RANGE;
              state_d      = S_DONE;
            end else begin
              lo_d    = req_i.start_page;
              hi_d    = free_hi;
              state_d = S_MREAD;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            cur_d     = '0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // prefetch the next byte while this one is examined
        ram_re  = 1'b1;
        run_d   = run_n;
        first_d = first_n;
        cur_d   = cur_inc;
        if (found_n) begin
          lo_d                = first_n;
          hi_d                = last_n;
          res_d.granted_page  = first_n;
          res_d.needs_zeroing = CNT_W'(first_n) < hwm_i;
          hwm_upd_o.en        = end_page > hwm_i;
          hwm_upd_o.page      = end_page;
          state_d             = S_MREAD;
        end else if (cur_q == BYTE_W'(MAP_BYTES - 1)) begin
          res_d.status = ST_NOSPACE;
          state_d      = S_DONE;
        end
      end
      S_MREAD: begin
        ram_re    = 1'b1;
        ram_raddr = lo_q[PAGE_W-1:LANE_W];
        cur_d     = lo_q[PAGE_W-1:LANE_W];
        state_d   = S_MARK;
      end
      S_MARK: begin
        // write back this byte, read the next one unless this is the run's last byte
        ram_we    = 1'b1;
        ram_wdata = mark_data;
        if (cur_q == hi_q[PAGE_W-1:LANE_W]) begin
          state_d = S_DONE;
        end else begin
          ram_re = 1'b1;
          cur_d  = cur_inc;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        cur_d   = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
    end
  end

  // Request and run payload
  always_ff @(posedge clk_i) begin
    run_q   <= run_d;
    first_q <= first_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    set_q   <= set_d;
    count_q <= count_d;
    res_q   <= res_d;
  end

endmodule
